// File: hw/rtl/set_assoc_cache_tag_controller_assert.svh
// Assertion macros for the cache tag controller checker.
// Expects signals named clk and rst_n in the scope where a macro is used.
`ifndef SET_ASSOC_CACHE_TAG_CONTROLLER_ASSERT_SVH
`define SET_ASSOC_CACHE_TAG_CONTROLLER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SACTC_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sactc check failed");

// Next-cycle implication, disabled during reset.
`define SACTC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sactc check failed");

`endif

// File: hw/rtl/sactc_pkg.sv
// Shared constants, types and codes of the cache tag controller.
// No dependencies; imported by every file but the assert header and sactc_ram.
package sactc_pkg;

    localparam int SETS_LOG2        = 6;
    localparam int WAYS             = 4;
    localparam int BLOCK_BYTES_LOG2 = 6;
    localparam int AGE_BITS         = 16;

    localparam int ADDR_W    = 32;
    localparam int DATA_W    = 32;
    localparam int PADDR_W   = 3;
    localparam int SETS      = 1 << SETS_LOG2;
    localparam int BLOCK_W   = ADDR_W - BLOCK_BYTES_LOG2;
    localparam int TAG_W     = BLOCK_W - SETS_LOG2;
    localparam int WAY_W     = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int WAY_OUT_W = 2;
    localparam int BLK_OUT_W = 26;

    localparam logic [AGE_BITS-1:0] AGE_MAX = {AGE_BITS{1'b1}};

    // Access kinds
    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    // Register index decoded from paddr
    localparam logic REG_MEMORY_BASE = 1'b0;

    typedef struct packed {
        logic [TAG_W-1:0]    tag;
        logic                dirty;
        logic [AGE_BITS-1:0] age;
    } line_t;

    typedef line_t [WAYS-1:0] row_t;

    localparam int ROW_W = $bits(row_t);

    typedef struct packed {
        logic capture;
        logic read;
        logic eval;
        logic commit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic in_valid;
        logic out_ready;
    } ctrl_sts_t;

    typedef struct packed {
        logic                 hit;
        logic [WAY_OUT_W-1:0] way_used;
        logic                 writeback;
        logic [BLK_OUT_W-1:0] writeback_block;
        logic                 fill;
        logic [BLK_OUT_W-1:0] fill_block;
    } rsp_t;

endpackage

// File: hw/rtl/sactc_if.sv
// Request and result channel interfaces of the cache tag controller.
// Depends on sactc_pkg for field widths.
interface sactc_req_if
    import sactc_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              cmd;
    logic [ADDR_W-1:0] address;

    modport source (output valid, output cmd, output address, input ready);
    modport sink   (input valid, input cmd, input address, output ready);
endinterface

interface sactc_rsp_if
    import sactc_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic                 hit;
    logic [WAY_OUT_W-1:0] way_used;
    logic                 writeback;
    logic [BLK_OUT_W-1:0] writeback_block;
    logic                 fill;
    logic [BLK_OUT_W-1:0] fill_block;

    modport source (output valid, output hit, output way_used, output writeback,
                    output writeback_block, output fill, output fill_block,
                    input ready);
    modport sink   (input valid, input hit, input way_used, input writeback,
                    input writeback_block, input fill, input fill_block,
                    output ready);
endinterface

// File: hw/rtl/sactc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sactc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic                                  re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: hw/rtl/sactc_ctrl.sv
// Sequencer of the cache tag controller: steps each request through
// capture, row read, evaluation and commit. Depends on sactc_pkg.
module sactc_ctrl
    import sactc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  ctrl_sts_t sts,
    output ctrl_cmd_t cmd,
    output logic      in_ready,
    output logic      out_valid
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_READ  = 2'd1;
    localparam logic [1:0] ST_EVAL  = 2'd2;
    localparam logic [1:0] ST_WRITE = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.capture = sts.in_valid;
                if (sts.in_valid)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                cmd.read   = 1'b1;
                state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                cmd.eval   = 1'b1;
                state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                // hold until the result slot is free or draining
                cmd.commit = !out_valid_reg || sts.out_ready;
                if (cmd.commit)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (sts.out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// File: hw/rtl/sactc_dp.sv
// Datapath of the cache tag controller: address split, tag/age/dirty row RAM,
// per-line valid bits, hit and victim selection, result register.
// Depends on sactc_pkg and sactc_ram.
module sactc_dp
    import sactc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  ctrl_cmd_t         cmd,
    input  logic [ADDR_W-1:0] memory_base,
    input  logic              req_cmd,
    input  logic [ADDR_W-1:0] req_address,
    output rsp_t              rsp
);

    logic                 is_write_reg;
    logic [BLOCK_W-1:0]   block_reg;
    logic                 hit_reg;
    logic [WAY_W-1:0]     way_reg;
    logic                 wb_reg;
    logic [TAG_W-1:0]     wb_tag_reg;
    row_t                 row_reg;
    logic [WAYS-1:0]      valid_reg [SETS];
    rsp_t                 rsp_reg;

    logic [ADDR_W-1:0]    offset;
    logic [SETS_LOG2-1:0] set;
    logic [TAG_W-1:0]     tag;
    logic [ROW_W-1:0]     ram_rdata;
    row_t                 rd_row;
    row_t                 new_row;
    logic [WAYS-1:0]      vrow;

    logic                 hit_c;
    logic [WAY_W-1:0]     hit_way_c;
    logic                 free_c;
    logic [WAY_W-1:0]     free_way_c;
    logic [WAY_W-1:0]     vic_c;
    logic [AGE_BITS-1:0]  best_c;
    logic [WAY_W-1:0]     way_c;
    logic                 wb_c;

    assign offset = req_address - memory_base;
    assign set    = block_reg[SETS_LOG2-1:0];
    assign tag    = block_reg[BLOCK_W-1:SETS_LOG2];
    assign rd_row = row_t'(ram_rdata);
    assign vrow   = valid_reg[set];

    sactc_ram #(
        .WIDTH (ROW_W),
        .DEPTH (SETS)
    ) u_row_ram (
        .clk   (clk),
        .we    (cmd.commit),
        .waddr (set),
        .wdata (new_row),
        .re    (cmd.read),
        .raddr (set),
        .rdata (ram_rdata)
    );

    // Lookup: first matching valid way, highest invalid way, oldest way.
    always_comb
    begin
        hit_c      = 1'b0;
        hit_way_c  = '0;
        free_c     = 1'b0;
        free_way_c = '0;
        for (int w = 0; w < WAYS; w++)
        begin
            if (vrow[w])
            begin
                if (!hit_c && (rd_row[w].tag == tag))
                begin
                    hit_c     = 1'b1;
                    hit_way_c = WAY_W'(w);
                end
            end
            else
            begin
                free_c     = 1'b1;
                free_way_c = WAY_W'(w);
            end
        end
        vic_c  = '0;
        best_c = rd_row[0].age;
        for (int w = 1; w < WAYS; w++)
        begin
            if (rd_row[w].age > best_c)
            begin
                best_c = rd_row[w].age;
                vic_c  = WAY_W'(w);
            end
        end
        way_c = hit_c ? hit_way_c : (free_c ? free_way_c : vic_c);
        wb_c  = !hit_c && !free_c && rd_row[vic_c].dirty;
    end

    // New row: used way gets age zero, new dirty, tag on a miss; others age up.
    always_comb
    begin
        for (int w = 0; w < WAYS; w++)
        begin
            new_row[w] = row_reg[w];
            if (WAY_W'(w) == way_reg)
            begin
                new_row[w].age = '0;
                if (hit_reg)
                begin
                    new_row[w].dirty = row_reg[w].dirty | is_write_reg;
                end
                else
                begin
                    new_row[w].tag   = tag;
                    new_row[w].dirty = is_write_reg;
                end
            end
            else if (row_reg[w].age != AGE_MAX)
            begin
                new_row[w].age = row_reg[w].age + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            is_write_reg <= (req_cmd == CMD_WRITE);
            block_reg    <= offset[ADDR_W-1:BLOCK_BYTES_LOG2];
        end
        if (cmd.eval)
        begin
            hit_reg    <= hit_c;
            way_reg    <= way_c;
            wb_reg     <= wb_c;
            wb_tag_reg <= rd_row[vic_c].tag;
            row_reg    <= rd_row;
        end
        if (cmd.commit)
        begin
            rsp_reg.hit             <= hit_reg;
            rsp_reg.way_used        <= WAY_OUT_W'(way_reg);
            rsp_reg.writeback       <= wb_reg;
            rsp_reg.writeback_block <= wb_reg ? BLK_OUT_W'({wb_tag_reg, set}) : '0;
            rsp_reg.fill            <= !hit_reg;
            rsp_reg.fill_block      <= hit_reg ? '0 : BLK_OUT_W'(block_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < SETS; s++)
            begin
                valid_reg[s] <= '0;
            end
        end
        else if (cmd.commit)
        begin
            valid_reg[set][way_reg] <= 1'b1;
        end
    end

    assign rsp = rsp_reg;

endmodule

// File: hw/rtl/set_assoc_cache_tag_controller.sv
// Top level of the set-associative write-back cache tag controller.
// Depends on sactc_pkg, sactc_if, sactc_ctrl, sactc_dp (and sactc_ram below it).
//
//   channel   direction  handshake        payload
//   -------   ---------  ---------------  -----------------------------------------
//   req       in         valid / ready    cmd, address
//   rsp       out        valid / ready    hit, way_used, writeback, writeback_block,
//                                         fill, fill_block
//   apb       in         psel / penable   paddr, pwdata (write), prdata (read)
//
// Each request steps through accept, read of the set's tag/dirty/age row from
// the row RAM (registered read port), lookup and victim pick, then commit
// of the updated row together with loading of the result register.
// A new request is accepted while the previous result still waits in the
// result register; commit of that new request holds until the slot drains.
// Reset clears the per-line valid bits at once; no clearing pass is needed,
// since tag, dirty and age of a line are only used after it has been filled.
// memory_base resets to zero and is written over the APB port at byte 0.
module set_assoc_cache_tag_controller
    import sactc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0]  pwdata,
    output logic [DATA_W-1:0]  prdata,
    output logic               pready,
    sactc_req_if.sink          req,
    sactc_rsp_if.source        rsp
);

    logic [ADDR_W-1:0] memory_base_reg;
    logic              cfg_write;
    ctrl_sts_t         sts;
    ctrl_cmd_t         cmd;
    logic              in_ready;
    logic              out_valid;
    rsp_t              rsp_data;

    // Register write at the access phase; byte offset bits are ignored.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == REG_MEMORY_BASE) ? memory_base_reg : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            memory_base_reg <= '0;
        end
        else if (cfg_write && (paddr[2] == REG_MEMORY_BASE))
        begin
            memory_base_reg <= pwdata;
        end
    end

    assign sts.in_valid  = req.valid;
    assign sts.out_ready = rsp.ready;

    sactc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .sts       (sts),
        .cmd       (cmd),
        .in_ready  (in_ready),
        .out_valid (out_valid)
    );

    // The datapath subtracts memory_base from the request address at accept.
    sactc_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .memory_base (memory_base_reg),
        .req_cmd     (req.cmd),
        .req_address (req.address),
        .rsp         (rsp_data)
    );

    assign req.ready           = in_ready;
    assign rsp.valid           = out_valid;
    assign rsp.hit             = rsp_data.hit;
    assign rsp.way_used        = rsp_data.way_used;
    assign rsp.writeback       = rsp_data.writeback;
    assign rsp.writeback_block = rsp_data.writeback_block;
    assign rsp.fill            = rsp_data.fill;
    assign rsp.fill_block      = rsp_data.fill_block;

endmodule

// File: hw/rtl/sactc_checker.sv
// Port-level checks of the cache tag controller, bound to the top level.
// Depends on sactc_pkg and set_assoc_cache_tag_controller_assert.svh.
`include "set_assoc_cache_tag_controller_assert.svh"

module sactc_checker
    import sactc_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic req_valid,
    input logic req_ready,
    input logic rsp_valid,
    input logic rsp_ready,
    input logic rsp_hit,
    input logic rsp_fill,
    input logic rsp_writeback
);

    // Busy right after a request is taken.
    `SACTC_ASSERT_NEXT(busy_after_accept, req_valid && req_ready, !req_ready)

    // A fresh result only comes out of the commit step, never from idle.
    `SACTC_ASSERT_NOW(result_from_commit, $rose(rsp_valid), !$past(req_ready))

    // A writeback goes with a miss fill.
    `SACTC_ASSERT_NOW(wb_needs_miss, rsp_valid && rsp_writeback,
                      rsp_fill && !rsp_hit)

    // Hold a stalled result.
    `SACTC_ASSERT_NEXT(rsp_hold, rsp_valid && !rsp_ready, rsp_valid)

endmodule

bind set_assoc_cache_tag_controller sactc_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .req_valid     (req.valid),
    .req_ready     (req.ready),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .rsp_hit       (rsp.hit),
    .rsp_fill      (rsp.fill),
    .rsp_writeback (rsp.writeback)
);
